/* hdl/csd_pkg.sv */
// ----------------------------------------------------------------------------
// csd_pkg
// Shared widths, register codes and pipeline payload types for the capsule
// signed distance block.
// ----------------------------------------------------------------------------
package csd_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int CRD_W     = 32;   // coordinate width
  localparam int RAD_W     = 31;   // radius width
  localparam int ADDR_W    = 5;    // byte address of register 6 is 24

  // difference and dot product widths
  localparam int PA_W   = CRD_W + 1;          // |P - A| < 2^32
  localparam int PROD_W = 2 * PA_W;
  localparam int NUM_W  = PROD_W + 1;         // sum of three signed products
  localparam int DEN_W  = PROD_W;             // sum of three squares
  localparam int REM_W  = DEN_W + 1;          // divider remainder
  localparam int H_W    = FRAC_BITS + 1;      // segment parameter, 0..1.0

  // offset and length widths
  localparam int T_W    = PA_W + H_W + 1;     // BA * h
  localparam int QM_W   = PA_W + FRAC_BITS;   // offset magnitude
  localparam int Q_W    = QM_W + 1;           // signed offset
  localparam int LO_W   = (QM_W + 1) / 2;     // low half for square split
  localparam int HI_W   = QM_W - LO_W;
  localparam int SQ_W   = 2 * QM_W;           // one squared component
  localparam int S_W    = SQ_W + 2;           // sum of three squares
  localparam int ROOT_W = QM_W + 1;           // floor(sqrt(S))
  localparam int LEN_W  = ROOT_W + 1 - FRAC_BITS;
  localparam int D_W    = LEN_W + 2;

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_A_X    = 3'd0,
    REG_A_Y    = 3'd1,
    REG_A_Z    = 3'd2,
    REG_B_X    = 3'd3,
    REG_B_Y    = 3'd4,
    REG_B_Z    = 3'd5,
    REG_RADIUS = 3'd6
  } reg_idx_t;

  // register file contents
  typedef struct packed {
    logic signed [CRD_W-1:0] a_x;
    logic signed [CRD_W-1:0] a_y;
    logic signed [CRD_W-1:0] a_z;
    logic signed [CRD_W-1:0] b_x;
    logic signed [CRD_W-1:0] b_y;
    logic signed [CRD_W-1:0] b_z;
    logic        [RAD_W-1:0] radius;
  } csd_cfg_t;

  // three-component difference vector, elements are two's complement
  typedef logic [2:0][PA_W-1:0] pa_vec_t;

  // divider beat
  typedef struct packed {
    pa_vec_t              pa;
    logic [DEN_W-1:0]     den;
    logic [REM_W-1:0]     rem;
    logic [FRAC_BITS-1:0] quo;
    logic                 dv;    // quotient is computed
    logic                 hsat;  // parameter clamps to 1.0
  } div_pay_t;

endpackage

/* hdl/csd_if.sv */
// ----------------------------------------------------------------------------
// csd_in_if / csd_out_if
// Valid/ready channels for query points and distance results.
// ----------------------------------------------------------------------------
interface csd_in_if import csd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] query_x;
  logic signed [CRD_W-1:0] query_y;
  logic signed [CRD_W-1:0] query_z;

  modport source (output valid, output query_x, output query_y, output query_z,
                  input ready);
  modport sink   (input valid, input query_x, input query_y, input query_z,
                  output ready);
endinterface

interface csd_out_if import csd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] signed_distance;

  modport source (output valid, output signed_distance, input ready);
  modport sink   (input valid, input signed_distance, output ready);
endinterface

/* hdl/capsule_signed_distance.sv */
// ----------------------------------------------------------------------------
// capsule_signed_distance
// Signed distance from a query point to a capsule, fully pipelined.
// ----------------------------------------------------------------------------
// One query point is taken every clock cycle while the result side is not
// stalled, and one Q16.16 distance comes out per point, in order. Three
// stages form P-A and the dot products, FRAC_BITS divider stages give the
// segment parameter, five stages form the offset and its squared length,
// ROOT_W square-root stages (one root bit each) and one output register
// finish the Q16.16 result. A stall on the result side freezes the whole
// pipeline; no beat is lost. The endpoints and radius sit in an APB
// register file and may be changed only while no point is in flight.
// ----------------------------------------------------------------------------
module capsule_signed_distance import csd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  csd_in_if.sink            in_pt,
  csd_out_if.source         out_res
);

  csd_cfg_t cfg;
  pa_vec_t  ba;
  pa_vec_t  pa;
  logic     en;

  csd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // global advance: move whenever the output slot is free or drained
  logic out_vld_r;
  logic signed [CRD_W-1:0] dist_r;
  assign en           = !out_vld_r || out_res.ready;
  assign in_pt.ready  = en;

  // segment direction, stable while points are in flight only if the user leaves the registers unwritten
  assign ba[0] = PA_W'(cfg.b_x) - PA_W'(cfg.a_x);
  assign ba[1] = PA_W'(cfg.b_y) - PA_W'(cfg.a_y);
  assign ba[2] = PA_W'(cfg.b_z) - PA_W'(cfg.a_z);
  assign pa[0] = PA_W'(in_pt.query_x) - PA_W'(cfg.a_x);
  assign pa[1] = PA_W'(in_pt.query_y) - PA_W'(cfg.a_y);
  assign pa[2] = PA_W'(in_pt.query_z) - PA_W'(cfg.a_z);

  // stage 1: P - A
  logic    v1_r;
  pa_vec_t pa1_r;
  // stage 2: products
  logic                     v2_r;
  pa_vec_t                  pa2_r;
  logic signed [PROD_W-1:0] np_r [3];
  logic signed [PROD_W-1:0] dp_r [3];
  // stage 3: dot products and clamp decision
  logic     v3_r;
  div_pay_t p3_r;
  logic signed [NUM_W-1:0] num;
  logic        [DEN_W-1:0] den;
  logic                    num_pos;
  logic                    num_ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_pt.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa1_r <= pa;
      pa2_r <= pa1_r;
      for (int i = 0; i < 3; i++) begin
        np_r[i] <= $signed(pa1_r[i]) * $signed(ba[i]);
        dp_r[i] <= $signed(ba[i]) * $signed(ba[i]);
      end
    end
  end

  assign num = NUM_W'(np_r[0]) + NUM_W'(np_r[1]) + NUM_W'(np_r[2]);
  assign den = DEN_W'(dp_r[0]) + DEN_W'(dp_r[1]) + DEN_W'(dp_r[2]);
  assign num_pos = !num[NUM_W-1] && (num != '0);
  assign num_ge  = num >= $signed({1'b0, den});

  // degenerate segment or point behind A: parameter is zero; past B: clamps to 1.0
  always_ff @(posedge clk) begin
    if (en) begin
      p3_r.pa   <= pa2_r;
      p3_r.den  <= den;
      p3_r.quo  <= '0;
      p3_r.dv   <= (den != '0) && num_pos && !num_ge;
      p3_r.hsat <= (den != '0) && num_pos && num_ge;
      p3_r.rem  <= ((den != '0) && num_pos && !num_ge) ? REM_W'(num) : '0;
    end
  end

  // segment parameter
  logic           vd;
  pa_vec_t        pad;
  logic [H_W-1:0] hd;

  csd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v3_r),
    .in_pay  (p3_r),
    .out_vld (vd),
    .out_pa  (pad),
    .out_h   (hd)
  );

  // stage 4: BA * h ; stage 5: |PA*2^F - BA*h|
  logic                  v4_r, v5_r;
  pa_vec_t               pa4_r;
  logic signed [T_W-1:0] t_r  [3];
  logic        [QM_W-1:0] qm_r [3];
  logic signed [Q_W-1:0]  q    [3];
  // stage 6..8: squares and sum
  logic                    v6_r, v7_r, v8_r;
  logic [2*HI_W-1:0]       hh_r [3];
  logic [HI_W+LO_W-1:0]    hl_r [3];
  logic [2*LO_W-1:0]       ll_r [3];
  logic [SQ_W-1:0]         sq_r [3];
  logic [S_W-1:0]          s_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = (Q_W'($signed(pa4_r[i])) <<< FRAC_BITS) - Q_W'(t_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v4_r <= vd;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa4_r <= pad;
      for (int i = 0; i < 3; i++) begin
        t_r[i]  <= $signed(ba[i]) * $signed({1'b0, hd});
        qm_r[i] <= q[i][Q_W-1] ? QM_W'(-q[i]) : QM_W'(q[i]);
        hh_r[i] <= qm_r[i][QM_W-1:LO_W] * qm_r[i][QM_W-1:LO_W];
        hl_r[i] <= qm_r[i][QM_W-1:LO_W] * qm_r[i][LO_W-1:0];
        ll_r[i] <= qm_r[i][LO_W-1:0] * qm_r[i][LO_W-1:0];
        sq_r[i] <= (SQ_W'(hh_r[i]) << (2 * LO_W)) + (SQ_W'(hl_r[i]) << (LO_W + 1))
                   + SQ_W'(ll_r[i]);
      end
      s_r <= S_W'(sq_r[0]) + S_W'(sq_r[1]) + S_W'(sq_r[2]);
    end
  end

  // length
  logic              vr;
  logic [ROOT_W-1:0] root;

  csd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v8_r),
    .in_sum   (s_r),
    .out_vld  (vr),
    .out_root (root)
  );

  // round, subtract radius, saturate
  logic [ROOT_W:0]       rnd;
  logic [LEN_W-1:0]      len;
  logic signed [D_W-1:0] d;
  logic signed [D_W-1:0] d_max;
  logic signed [D_W-1:0] d_min;

  assign rnd   = {1'b0, root} + ((ROOT_W + 1)'(1) << (FRAC_BITS - 1));
  assign len   = rnd[ROOT_W:FRAC_BITS];
  assign d     = $signed(D_W'(len)) - $signed(D_W'(cfg.radius));
  assign d_max = D_W'(32'sh7FFF_FFFF);
  assign d_min = -(D_W'(33'sh0_8000_0000));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d > d_max) begin
        dist_r <= d_max[CRD_W-1:0];
      end else if (d < d_min) begin
        dist_r <= d_min[CRD_W-1:0];
      end else begin
        dist_r <= d[CRD_W-1:0];
      end
    end
  end

  assign out_res.valid           = out_vld_r;
  assign out_res.signed_distance = dist_r;

  // accepted beat enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pt.valid && in_pt.ready) |=> v1_r)
    else $error("accepted beat missing from first stage");

  // a stalled result freezes the pipeline
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_res.ready) |=> ($stable(v1_r) && $stable(v8_r) && out_vld_r))
    else $error("pipeline moved during output stall");

  // reset empties the output slot
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_vld_r)
    else $error("result valid after reset");

endmodule

/* hdl/csd_cfg.sv */
// ----------------------------------------------------------------------------
// csd_cfg
// APB register file holding the capsule endpoints and radius.
// ----------------------------------------------------------------------------
module csd_cfg import csd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output csd_cfg_t          cfg
);

  csd_cfg_t cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a_x    <= '0;
      cfg_r.a_y    <= '0;
      cfg_r.a_z    <= '0;
      cfg_r.b_x    <= '0;
      cfg_r.b_y    <= CRD_W'(1) << FRAC_BITS;
      cfg_r.b_z    <= '0;
      cfg_r.radius <= RAD_W'(1) << FRAC_BITS;
    end else if (wr) begin
      unique case (idx)
        REG_A_X:    cfg_r.a_x    <= pwdata;
        REG_A_Y:    cfg_r.a_y    <= pwdata;
        REG_A_Z:    cfg_r.a_z    <= pwdata;
        REG_B_X:    cfg_r.b_x    <= pwdata;
        REG_B_Y:    cfg_r.b_y    <= pwdata;
        REG_B_Z:    cfg_r.b_z    <= pwdata;
        REG_RADIUS: cfg_r.radius <= pwdata[RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_A_X:    prdata = cfg_r.a_x;
      REG_A_Y:    prdata = cfg_r.a_y;
      REG_A_Z:    prdata = cfg_r.a_z;
      REG_B_X:    prdata = cfg_r.b_x;
      REG_B_Y:    prdata = cfg_r.b_y;
      REG_B_Z:    prdata = cfg_r.b_z;
      REG_RADIUS: prdata = {1'b0, cfg_r.radius};
      default:    prdata = '0;
    endcase
  end

endmodule

/* hdl/csd_div.sv */
// ----------------------------------------------------------------------------
// csd_div
// Pipelined restoring divider for the segment parameter, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module csd_div import csd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  div_pay_t       in_pay,
  output logic           out_vld,
  output pa_vec_t        out_pa,
  output logic [H_W-1:0] out_h
);

  div_pay_t pay_in [FRAC_BITS];
  div_pay_t pay_r  [FRAC_BITS];
  logic     vld_in [FRAC_BITS];
  logic     vld_r  [FRAC_BITS];

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_stage
    logic [REM_W-1:0] sh;
    logic             ge;
    div_pay_t         pay_nxt;

    if (j == 0) begin : g_first
      assign pay_in[j] = in_pay;
      assign vld_in[j] = in_vld;
    end else begin : g_next
      assign pay_in[j] = pay_r[j-1];
      assign vld_in[j] = vld_r[j-1];
    end

    // shift, trial subtract
    assign sh = {pay_in[j].rem[REM_W-2:0], 1'b0};
    assign ge = sh >= {1'b0, pay_in[j].den};

    // payload for the next stage
    always_comb begin
      pay_nxt     = pay_in[j];
      pay_nxt.rem = ge ? sh - {1'b0, pay_in[j].den} : sh;
      pay_nxt.quo = {pay_in[j].quo[FRAC_BITS-2:0], ge & pay_in[j].dv};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pay_r[j] <= pay_nxt;
      end
    end
  end

  assign out_vld = vld_r[FRAC_BITS-1];
  assign out_pa  = pay_r[FRAC_BITS-1].pa;
  assign out_h   = pay_r[FRAC_BITS-1].hsat ? (H_W'(1) << FRAC_BITS)
                                           : {1'b0, pay_r[FRAC_BITS-1].quo};

endmodule

/* hdl/csd_sqrt.sv */
// ----------------------------------------------------------------------------
// csd_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module csd_sqrt import csd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [S_W-1:0]    in_sum,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root
);

  logic [S_W-1:0]    rem_in  [ROOT_W];
  logic [ROOT_W-1:0] root_in [ROOT_W];
  logic              vld_in  [ROOT_W];
  logic [S_W-1:0]    rem_r   [ROOT_W];
  logic [ROOT_W-1:0] root_r  [ROOT_W];
  logic              vld_r   [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int K = ROOT_W - 1 - j;   // root bit decided here
    logic [S_W-1:0] trial;
    logic           ge;

    if (j == 0) begin : g_first
      assign rem_in[j]  = in_sum;
      assign root_in[j] = '0;
      assign vld_in[j]  = in_vld;
    end else begin : g_next
      assign rem_in[j]  = rem_r[j-1];
      assign root_in[j] = root_r[j-1];
      assign vld_in[j]  = vld_r[j-1];
    end

    // (R + 2^K)^2 - R^2 = R*2^(K+1) + 2^(2K)
    assign trial = (S_W'(root_in[j]) << (K + 1)) + (S_W'(1) << (2 * K));
    assign ge    = rem_in[j] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? rem_in[j] - trial : rem_in[j];
        root_r[j] <= ge ? (root_in[j] | (ROOT_W'(1) << K)) : root_in[j];
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];

endmodule

/* sim/csd_tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_tb_if
// Channel interfaces come from the design's own interface file; this file
// only holds the constants the testbench shares between its processes.
// ----------------------------------------------------------------------------
package csd_tb_pkg;
  localparam int CLK_HI    = 6;
  localparam int CLK_LO    = 6;
  localparam int RST_CYC   = 9;
  localparam int DRAIN_CYC = 100;   // wait for the pipeline to empty
  localparam int REG_NONE  = 7;     // address past the register file
endpackage

/* sim/capsule_signed_distance_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capsule_signed_distance_tb
// Self-checking bench: directed table then random points over several capsule
// settings, every result checked against a table value or an in-bench distance model.
// ----------------------------------------------------------------------------
module capsule_signed_distance_tb;
  import csd_pkg::*;
  import csd_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  csd_in_if  in_if ();
  csd_out_if out_if ();

  capsule_signed_distance dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_pt(in_if), .out_res(out_if)
  );

  always begin
    #CLK_HI clk = 1'b1;
    #CLK_LO clk = 1'b0;
  end

  // capsule copy held by the bench
  int ax, ay, az, bx, by, bz, rad;

  logic signed [31:0] dist_q[$];
  int mismatches = 0;
  int send_idle = 0;   // percent of cycles the sender stays idle
  int recv_stall = 0;  // percent of cycles the receiver stalls
  logic dir_chk = 1'b0;
  logic signed [31:0] dir_val = '0;

  // distance to the capsule surface, Q16.16 saturated
  function automatic logic signed [31:0] capsule_dist(int px, int py, int pz);
    logic signed [127:0] pa[3], ba[3], q[3];
    logic signed [127:0] num, den, h, d;
    logic [127:0] s, res, bt, t;
    pa[0] = 128'(px) - 128'(ax);
    pa[1] = 128'(py) - 128'(ay);
    pa[2] = 128'(pz) - 128'(az);
    ba[0] = 128'(bx) - 128'(ax);
    ba[1] = 128'(by) - 128'(ay);
    ba[2] = 128'(bz) - 128'(az);
    num = pa[0]*ba[0] + pa[1]*ba[1] + pa[2]*ba[2];
    den = ba[0]*ba[0] + ba[1]*ba[1] + ba[2]*ba[2];
    if (den == 0 || num <= 0) h = 0;
    else if (num >= den) h = 128'sd1 <<< FRAC_BITS;
    else h = (num <<< FRAC_BITS) / den;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      q[i] = (pa[i] <<< FRAC_BITS) - ba[i] * h;
      s = s + 128'(q[i] * q[i]);
    end
    // bitwise integer square root
    res = 0;
    bt = 128'd1 << 126;
    while (bt != 0 && bt > s) bt = bt >> 2;
    while (bt != 0) begin
      t = res + bt;
      if (s >= t) begin
        s = s - t;
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    d = $signed((res + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS) - 128'(rad);
    if (d > 128'sd2147483647) d = 128'sd2147483647;
    if (d < -128'sd2147483648) d = -128'sd2147483648;
    return d[31:0];
  endfunction

  // point beats: queue the expectation; result beats: check the oldest
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      dist_q.push_back(dir_chk ? dir_val :
                       capsule_dist(in_if.query_x, in_if.query_y, in_if.query_z));
    if (rst_n && out_if.valid && out_if.ready) begin
      if (dist_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: %0d", out_if.signed_distance);
      end else begin
        logic signed [31:0] want;
        want = dist_q.pop_front();
        if (want !== out_if.signed_distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("signed_distance mismatch: expected %0d, got %0d",
                     want, out_if.signed_distance);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk)
    out_if.ready = ($urandom_range(99) >= recv_stall);

  task automatic cfg_write(int idx, int val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = ADDR_W'(idx * 4); pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_A_X: ax = val;
      REG_A_Y: ay = val;
      REG_A_Z: az = val;
      REG_B_X: bx = val;
      REG_B_Y: by = val;
      REG_B_Z: bz = val;
      REG_RADIUS: rad = val & 32'h7fff_ffff;
      default: ;
    endcase
  endtask

  task automatic set_capsule(int a0, int a1, int a2, int b0, int b1, int b2, int r);
    // let the pipeline empty before touching the registers
    wait (dist_q.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_write(REG_A_X, a0); cfg_write(REG_A_Y, a1); cfg_write(REG_A_Z, a2);
    cfg_write(REG_B_X, b0); cfg_write(REG_B_Y, b1); cfg_write(REG_B_Z, b2);
    cfg_write(REG_RADIUS, r);
  endtask

  // one point beat; called at a falling edge, returns at a falling edge
  task automatic send_pt(int x, int y, int z, bit chk, int val);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.query_x = x; in_if.query_y = y; in_if.query_z = z;
    dir_chk = chk; dir_val = val;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    in_if.valid = 1'b0;
    dir_chk = 1'b0;
  endtask

  function automatic int near(int c);
    return c + $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
  endfunction

  typedef struct {
    int x, y, z;
    bit chk;
    int val;
  } pt_row_t;

  localparam int ONE = 65536;
  localparam int MX  = 32'sh7fff_ffff;
  localparam int MN  = -32'sh8000_0000;

  // directed table at reset capsule (A origin, B one up, radius one)
  pt_row_t dir_tab[] = '{
    '{0, 0, 0, 1, -ONE},            // on the axis at A
    '{0, ONE, 0, 1, -ONE},          // on the axis at B
    '{2*ONE, 0, 0, 1, ONE},         // beside A, parameter zero
    '{0, -3*ONE, 0, 1, 2*ONE},      // below A, clamps low
    '{0, 4*ONE, 0, 1, 2*ONE},       // above B, clamps high
    '{ONE, ONE/2, 0, 1, 0},         // on the surface mid-segment
    '{MX, MX, MX, 0, 0},
    '{MN, MN, MN, 0, 0},
    '{MX, MN, MX, 0, 0},
    '{MN, MX, MN, 0, 0},
    '{0, MX, 0, 0, 0},
    '{0, MN, 0, 0, 0},
    '{12345, -6789, 999, 0, 0},
    '{-1, -1, -1, 0, 0}
  };

  initial begin
    in_if.valid = 1'b0;
    in_if.query_x = '0; in_if.query_y = '0; in_if.query_z = '0;
    out_if.ready = 1'b0;
    ax = 0; ay = 0; az = 0; bx = 0; by = ONE; bz = 0; rad = ONE;
    repeat (RST_CYC) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_tab[i])
      send_pt(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].chk, dir_tab[i].val);

    // degenerate segment: A equals B
    set_capsule(ONE, ONE, ONE, ONE, ONE, ONE, ONE);
    send_pt(ONE, ONE, ONE, 1, -ONE);
    send_pt(3*ONE, ONE, ONE, 1, ONE);
    // extreme endpoints, no radius: far point saturates high
    set_capsule(MN, MN, MN, MN, MN, MN, 0);
    cfg_write(REG_NONE, 32'h1234_5678);   // ignored
    send_pt(MX, MX, MX, 1, MX);
    send_pt(MN, MN, MN, 1, 0);
    set_capsule(MN, MN, MN, MX, MX, MX, MX);
    send_pt(0, 0, 0, 0, 0);
    send_pt(MX, MN, 0, 0, 0);

    // random phases with mixed capsules and idling
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 55; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 55; end
        default: begin send_idle = 34; recv_stall = 34; end
      endcase
      case (ph % 5)
        0: set_capsule($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom);
        1: set_capsule(near(0), near(0), near(0), near(0), near(0), near(0),
                       $urandom_range(0, 4*ONE));
        2: set_capsule(MX, MN, MX, MN, MX, MN, 0);
        3: begin
          int c;
          c = $urandom;
          set_capsule(c, near(0), c, c, near(0), c, $urandom_range(0, MX));
        end
        default: set_capsule(near(0), near(0), near(0), near(0), near(0), near(0),
                             MX);
      endcase
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(2) == 0)
          send_pt($urandom, $urandom, $urandom, 0, 0);
        else
          send_pt(near(($urandom_range(1)) ? ax : bx), near(ay), near(bz), 0, 0);
      end
    end

    wait (dist_q.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
hdl/csd_pkg.sv
hdl/csd_if.sv
hdl/csd_cfg.sv
hdl/csd_div.sv
hdl/csd_sqrt.sv
hdl/capsule_signed_distance.sv
sim/csd_tb_if.sv
sim/capsule_signed_distance_tb.sv
